// File: rtl/sedc_pkg.sv
// ----------------------------------------------------------------------------
// Sensor event confirm detector: shared types and constants
// Config register map, item kinds, phase codes and the queue word that
// travels from the front to the back.
// ----------------------------------------------------------------------------
package sedc_pkg;

   localparam int ACCEL_W     = 16;
   localparam int SQ_W        = 32;   // 3 * 2^30 fits
   localparam int PRES_W      = 20;
   localparam int VIB_W       = 16;
   localparam int TIME_W      = 32;
   localparam int MAG_W       = 16;
   localparam int SUM_W       = 20;
   localparam int HIT_W       = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int RISE_W      = 30;   // 20-bit rise times 1000
   localparam int LIM_W       = 52;   // 20-bit threshold times 32-bit dt
   localparam int QUEUE_DEPTH = 2;
   localparam int ROOT_STEPS  = 16;   // one result bit per step
   localparam int AXIS_COUNT  = 3;

   localparam logic [9:0] RISE_SCALE = 10'd1000;   // ms per second

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCENARIO  = 3'd0,
      CSR_IMPACT    = 3'd1,
      CSR_FREE_FALL = 3'd2,
      CSR_VIBRATION = 3'd3,
      CSR_PRES_RATE = 3'd4,
      CSR_WINDOW    = 3'd5,
      CSR_CONFIRM   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_FREE_FALL = 2'd0,
      KIND_SINKING   = 2'd1,
      KIND_IMPACT    = 2'd2,
      KIND_MANUAL    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_ARMED     = 2'd0,
      PH_DETECTING = 2'd1,
      PH_CONFIRMED = 2'd2,
      PH_ACTIVATED = 2'd3
   } phase_type;

   typedef struct packed {
      logic [1:0]        scenario;
      logic [15:0]       impact_threshold;
      logic [15:0]       free_fall_threshold;
      logic [15:0]       vibration_threshold;
      logic [PRES_W-1:0] pressure_rate_threshold;
      logic [15:0]       window_ms;
      logic [HIT_W-1:0]  confirm_samples;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      scenario:                2'd0,
      impact_threshold:        16'd8192,
      free_fall_threshold:     16'd512,
      vibration_threshold:     16'd100,
      pressure_rate_threshold: 20'd480,
      window_ms:               16'd500,
      confirm_samples:         8'd3
   };

   typedef struct packed {
      kind_type          kind;
      logic [SQ_W-1:0]   sq;
      logic [PRES_W-1:0] pres;
      logic [VIB_W-1:0]  vib;
      logic [TIME_W-1:0] now;
   } entry_type;

endpackage

// File: rtl/sedc_front.sv
// ----------------------------------------------------------------------------
// Sensor event confirm detector: front end
// Accepts a sample word, classifies it by scenario and, for free fall and impact, forms the
// squared acceleration magnitude with one shared squarer, then pushes to the queue.
// ----------------------------------------------------------------------------
module sedc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  sedc_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [15:0]            req_accel_x_val,
   input  logic signed [15:0]            req_accel_y_val,
   input  logic signed [15:0]            req_accel_z_val,
   input  logic [sedc_pkg::PRES_W-1:0]   req_pressure_val,
   input  logic [sedc_pkg::VIB_W-1:0]    req_vibration_hz,
   input  logic [sedc_pkg::TIME_W-1:0]   req_time_ms,
   output logic                          push_valid,
   input  logic                          push_ready,
   output sedc_pkg::entry_type           push_data
);

   typedef enum logic [1:0] {
      F_IDLE,
      F_SQUARE,
      F_PUSH
   } front_state_type;

   front_state_type            state_ff;
   logic [1:0]                 axis_ff;
   logic signed [15:0]         ax_ff, ay_ff, az_ff;
   sedc_pkg::entry_type        entry_ff;
   sedc_pkg::kind_type         kind_in;
   logic signed [15:0]         axis_sel;
   logic signed [31:0]         square;

   assign req_ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_data  = entry_ff;

   always_comb begin
      unique case (cfg.scenario)
         2'd0:    kind_in = sedc_pkg::KIND_FREE_FALL;
         2'd1:    kind_in = sedc_pkg::KIND_SINKING;
         2'd2:    kind_in = sedc_pkg::KIND_IMPACT;
         default: kind_in = sedc_pkg::KIND_MANUAL;
      endcase
   end

   always_comb begin
      case (axis_ff)
         2'd0:    axis_sel = ax_ff;
         2'd1:    axis_sel = ay_ff;
         default: axis_sel = az_ff;
      endcase
   end

   assign square = axis_sel * axis_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         axis_ff  <= 2'd0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  ax_ff          <= req_accel_x_val;
                  ay_ff          <= req_accel_y_val;
                  az_ff          <= req_accel_z_val;
                  entry_ff.kind  <= kind_in;
                  entry_ff.sq    <= '0;
                  entry_ff.pres  <= req_pressure_val;
                  entry_ff.vib   <= req_vibration_hz;
                  entry_ff.now   <= req_time_ms;
                  axis_ff        <= 2'd0;
                  // sinking and manual never look at the magnitude
                  if (kind_in == sedc_pkg::KIND_FREE_FALL ||
                      kind_in == sedc_pkg::KIND_IMPACT) begin
                     state_ff <= F_SQUARE;
                  end else begin
                     state_ff <= F_PUSH;
                  end
               end
            end
            F_SQUARE: begin
               entry_ff.sq <= entry_ff.sq + {1'b0, square[30:0]};
               axis_ff     <= axis_ff + 2'd1;
               if (axis_ff == 2'(sedc_pkg::AXIS_COUNT - 1)) begin
                  state_ff <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (push_ready) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/sedc_queue.sv
// ----------------------------------------------------------------------------
// Sensor event confirm detector: work queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module sedc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  sedc_pkg::entry_type  push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output sedc_pkg::entry_type  pop_data
);

   localparam int DEPTH = sedc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sedc_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: rtl/sedc_back.sv
// ----------------------------------------------------------------------------
// Sensor event confirm detector: back end
// Runs the selected detector on one queued word (bit-serial square root and
// moving sum, pressure rate, impact compare), steps the confirmation phase
// and holds the result word in an output register.
// ----------------------------------------------------------------------------
module sedc_back #(
   parameter int AVG_DEPTH = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sedc_pkg::cfg_type    cfg,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  sedc_pkg::entry_type  pop_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_activate,
   output logic                 rsp_event_now,
   output logic [1:0]           rsp_phase
);

   localparam int POS_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int FILL_W = $clog2(AVG_DEPTH + 1);
   localparam int CMP_W  = sedc_pkg::SUM_W + FILL_W;
   localparam int REM_W  = 19;
   localparam int STEP_W = $clog2(sedc_pkg::ROOT_STEPS);

   typedef enum logic [3:0] {
      B_IDLE,
      B_ROOT,
      B_RING,
      B_FF_CMP,
      B_SINK_MUL,
      B_SINK_CMP,
      B_IMP_MUL,
      B_IMP_CMP,
      B_DONE
   } back_state_type;

   back_state_type                  state_ff;
   sedc_pkg::entry_type             cur_ff;
   logic                            ev_ff;

   // square root datapath
   logic [sedc_pkg::SQ_W-1:0]       rad_ff;
   logic [sedc_pkg::MAG_W-1:0]      root_ff, root_in;
   logic [REM_W-1:0]                rem_ff, rem_in, rem_shift, trial;
   logic [STEP_W-1:0]               step_ff;

   // moving sum
   logic [sedc_pkg::MAG_W-1:0]      ring_ff [AVG_DEPTH];
   logic [sedc_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [POS_W-1:0]                pos_ff;
   logic [FILL_W-1:0]               fill_ff;
   logic [CMP_W-1:0]                ff_limit;

   // sinking and impact
   logic [sedc_pkg::PRES_W-1:0]     prev_pres_ff;
   logic [sedc_pkg::TIME_W-1:0]     prev_time_ff, dt;
   logic [sedc_pkg::RISE_W-1:0]     rise_ff;
   logic [sedc_pkg::LIM_W-1:0]      lim_ff;
   logic [sedc_pkg::SQ_W-1:0]       thr_sq_ff;

   // confirmation phase
   sedc_pkg::phase_type             phase_ff, phase_in;
   logic [sedc_pkg::TIME_W-1:0]     wstart_ff, wstart_in;
   logic [sedc_pkg::HIT_W-1:0]      hit_ff, hit_in, hit_inc;
   logic                            act_in;

   // result register
   logic                            rsp_valid_ff;
   logic                            rsp_activate_ff;
   logic                            rsp_event_ff;
   sedc_pkg::phase_type             rsp_phase_ff;
   logic                            out_free;

   assign pop_ready     = (state_ff == B_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_activate  = rsp_activate_ff;
   assign rsp_event_now = rsp_event_ff;
   assign rsp_phase     = rsp_phase_ff;
   assign out_free      = !rsp_valid_ff || rsp_ready;

   // one root bit per step: bring down two radicand bits, try subtract
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[sedc_pkg::SQ_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};

   always_comb begin
      if (rem_shift >= trial) begin
         rem_in  = rem_shift - trial;
         root_in = {root_ff[sedc_pkg::MAG_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_shift;
         root_in = {root_ff[sedc_pkg::MAG_W-2:0], 1'b0};
      end
   end

   assign sum_in   = sum_ff - ring_ff[pos_ff] + sedc_pkg::SUM_W'(root_ff);
   assign ff_limit = CMP_W'(cfg.free_fall_threshold) * CMP_W'(fill_ff);
   assign dt       = cur_ff.now - prev_time_ff;
   assign hit_inc  = (hit_ff == '1) ? hit_ff : hit_ff + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      wstart_in = wstart_ff;
      hit_in    = hit_ff;
      act_in    = 1'b0;
      if (cur_ff.kind != sedc_pkg::KIND_MANUAL) begin
         unique case (phase_ff)
            sedc_pkg::PH_ARMED: begin
               if (ev_ff) begin
                  phase_in  = sedc_pkg::PH_DETECTING;
                  wstart_in = cur_ff.now;
                  hit_in    = '0;
               end
            end
            sedc_pkg::PH_DETECTING: begin
               if (ev_ff) begin
                  hit_in = hit_inc;
                  if (hit_inc >= cfg.confirm_samples) begin
                     phase_in = sedc_pkg::PH_CONFIRMED;
                  end
               end else if ((cur_ff.now - wstart_ff) > {16'd0, cfg.window_ms}) begin
                  phase_in = sedc_pkg::PH_ARMED;
               end
            end
            sedc_pkg::PH_CONFIRMED: begin
               phase_in = sedc_pkg::PH_ACTIVATED;
               act_in   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= B_IDLE;
         ev_ff           <= 1'b0;
         sum_ff          <= '0;
         pos_ff          <= '0;
         fill_ff         <= '0;
         prev_pres_ff    <= '0;
         prev_time_ff    <= '0;
         phase_ff        <= sedc_pkg::PH_ARMED;
         wstart_ff       <= '0;
         hit_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         rsp_activate_ff <= 1'b0;
         rsp_event_ff    <= 1'b0;
         rsp_phase_ff    <= sedc_pkg::PH_ARMED;
         for (int i = 0; i < AVG_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  cur_ff  <= pop_data;
                  ev_ff   <= 1'b0;
                  rad_ff  <= pop_data.sq;
                  root_ff <= '0;
                  rem_ff  <= '0;
                  step_ff <= '0;
                  unique case (pop_data.kind)
                     sedc_pkg::KIND_FREE_FALL: state_ff <= B_ROOT;
                     sedc_pkg::KIND_SINKING:   state_ff <= B_SINK_MUL;
                     sedc_pkg::KIND_IMPACT:    state_ff <= B_IMP_MUL;
                     default:                  state_ff <= B_DONE;
                  endcase
               end
            end
            B_ROOT: begin
               rad_ff  <= {rad_ff[sedc_pkg::SQ_W-3:0], 2'b00};
               rem_ff  <= rem_in;
               root_ff <= root_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(sedc_pkg::ROOT_STEPS - 1)) begin
                  state_ff <= B_RING;
               end
            end
            B_RING: begin
               // replace the oldest magnitude and advance the ring
               sum_ff          <= sum_in;
               ring_ff[pos_ff] <= root_ff;
               pos_ff          <= (pos_ff == POS_W'(AVG_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
               if (fill_ff != FILL_W'(AVG_DEPTH)) begin
                  fill_ff <= fill_ff + 1'b1;
               end
               state_ff <= B_FF_CMP;
            end
            B_FF_CMP: begin
               ev_ff    <= (CMP_W'(sum_ff) < ff_limit) &&
                           (cur_ff.vib > cfg.vibration_threshold);
               state_ff <= B_DONE;
            end
            B_SINK_MUL: begin
               if (prev_time_ff == '0) begin
                  // no reference time yet (zero): take this sample as the reference
                  prev_pres_ff <= cur_ff.pres;
                  prev_time_ff <= cur_ff.now;
                  state_ff     <= B_DONE;
               end else if (dt == '0) begin
                  state_ff <= B_DONE;
               end else begin
                  lim_ff <= cfg.pressure_rate_threshold * dt;
                  if (cur_ff.pres > prev_pres_ff) begin
                     rise_ff <= (cur_ff.pres - prev_pres_ff) * sedc_pkg::RISE_SCALE;
                  end else begin
                     rise_ff <= '0;
                  end
                  prev_pres_ff <= cur_ff.pres;
                  prev_time_ff <= cur_ff.now;
                  state_ff     <= B_SINK_CMP;
               end
            end
            B_SINK_CMP: begin
               ev_ff    <= sedc_pkg::LIM_W'(rise_ff) > lim_ff;
               state_ff <= B_DONE;
            end
            B_IMP_MUL: begin
               thr_sq_ff <= cfg.impact_threshold * cfg.impact_threshold;
               state_ff  <= B_IMP_CMP;
            end
            B_IMP_CMP: begin
               ev_ff    <= cur_ff.sq > thr_sq_ff;
               state_ff <= B_DONE;
            end
            B_DONE: begin
               if (out_free) begin
                  phase_ff        <= phase_in;
                  wstart_ff       <= wstart_in;
                  hit_ff          <= hit_in;
                  rsp_valid_ff    <= 1'b1;
                  rsp_activate_ff <= act_in;
                  rsp_event_ff    <= ev_ff;
                  rsp_phase_ff    <= phase_in;
                  state_ff        <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   a_activated_terminal: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sedc_pkg::PH_ACTIVATED |=> phase_ff == sedc_pkg::PH_ACTIVATED)
      else $error("activated phase left before reset");

   a_activate_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_activate_ff |-> rsp_phase_ff == sedc_pkg::PH_ACTIVATED)
      else $error("activate pulse without activated phase");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(AVG_DEPTH))
      else $error("ring fill beyond depth");

   a_root_to_ring: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_ROOT && step_ff == STEP_W'(sedc_pkg::ROOT_STEPS - 1)
      |=> state_ff == B_RING)
      else $error("square root did not hand over to the ring update");

endmodule

// File: rtl/sensor_event_confirm_detector.sv
// ----------------------------------------------------------------------------
// Sensor event confirm detector
// Threshold event detector with confirmation: free fall, sinking and impact
// detectors feed an armed/detecting/confirmed/activated phase sequence.
// ----------------------------------------------------------------------------
// Flow: the front squares the three axes in turn (free fall, impact) or
//   goes straight to the push state (sinking, manual); the back runs the
//   selected detector states, then hands the result to the output register.
// Pacing: free fall is held back by the 16-step bit-serial square root in
//   the back end, which takes no new word until the last result is registered.
// Reset: synchronous; config returns to defaults, ring, sums and phase clear.
// ----------------------------------------------------------------------------
module sensor_event_confirm_detector #(
   parameter int AVG_DEPTH = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sedc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sedc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // sample words in
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [15:0]                req_accel_x_val,
   input  logic signed [15:0]                req_accel_y_val,
   input  logic signed [15:0]                req_accel_z_val,
   input  logic [sedc_pkg::PRES_W-1:0]       req_pressure_val,
   input  logic [sedc_pkg::VIB_W-1:0]        req_vibration_hz,
   input  logic [sedc_pkg::TIME_W-1:0]       req_time_ms,
   // result words out
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_activate,
   output logic                              rsp_event_now,
   output logic [1:0]                        rsp_phase
);

   sedc_pkg::cfg_type     cfg_ff;
   logic                  push_valid, push_ready;
   logic                  pop_valid, pop_ready;
   sedc_pkg::entry_type   push_data, pop_data;

   // Config writes are always accepted and registered into cfg_ff; writes past the map are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= sedc_pkg::CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            sedc_pkg::CSR_SCENARIO:  cfg_ff.scenario            <= csr_wdata[1:0];
            sedc_pkg::CSR_IMPACT:    cfg_ff.impact_threshold    <= csr_wdata[15:0];
            sedc_pkg::CSR_FREE_FALL: cfg_ff.free_fall_threshold <= csr_wdata[15:0];
            sedc_pkg::CSR_VIBRATION: cfg_ff.vibration_threshold <= csr_wdata[15:0];
            sedc_pkg::CSR_PRES_RATE:
               cfg_ff.pressure_rate_threshold <= csr_wdata[sedc_pkg::PRES_W-1:0];
            sedc_pkg::CSR_WINDOW:    cfg_ff.window_ms           <= csr_wdata[15:0];
            sedc_pkg::CSR_CONFIRM:
               cfg_ff.confirm_samples <= csr_wdata[sedc_pkg::HIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Front: accept, classify by scenario, square the axes for free fall and impact.
   sedc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_accel_x_val  (req_accel_x_val),
      .req_accel_y_val  (req_accel_y_val),
      .req_accel_z_val  (req_accel_z_val),
      .req_pressure_val (req_pressure_val),
      .req_vibration_hz (req_vibration_hz),
      .req_time_ms      (req_time_ms),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   // Queue: lets the front take the next sample while the back grinds.
   sedc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back: detectors, phase sequence and the result register.
   sedc_back #(
      .AVG_DEPTH (AVG_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_data      (pop_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_activate  (rsp_activate),
      .rsp_event_now (rsp_event_now),
      .rsp_phase     (rsp_phase)
   );

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Sensor event confirm detector testbench
// Drives sensor sample words through the detector under changing scenario and
// threshold settings. A scoreboard predicts the result word of every accepted
// sample and checks each returned word field by field. Both channels idle and
// stall at random. The run closes by confirming and then activating once.
// ----------------------------------------------------------------------------
module tb_top;
   import sedc_pkg::*;

   localparam int AVG_DEPTH     = 10;
   localparam int SETTLE_CYCLES = 40;        // longer than the free-fall path
   localparam int LIMIT_CYCLES  = 600000;
   localparam int SEGMENTS      = 15;
   localparam int SEG_SAMPLES   = 80;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;   // unmapped index
   localparam logic [15:0]          AXIS_MIN   = 16'h8000;
   localparam logic [15:0]          AXIS_MAX   = 16'h7FFF;

   typedef struct {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [PRES_W-1:0]  pressure;
      logic [VIB_W-1:0]   vibration_hz;
      logic [TIME_W-1:0]  time_ms;
   } sample_t;

   typedef struct {
      logic      activate;
      logic      event_now;
      phase_type phase;
   } outcome_t;

   typedef struct {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } reg_write_t;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the detector state and settings, plus the
   // outcomes still waiting for their result word.
   // -------------------------------------------------------------------------
   class detector_scoreboard;
      cfg_type           cfg;
      logic [15:0]       mag_ring [AVG_DEPTH];
      logic [SUM_W-1:0]  mag_sum;
      int unsigned       ring_pos;
      int unsigned       ring_fill;
      logic [PRES_W-1:0] prev_pressure;
      logic [TIME_W-1:0] prev_time;
      phase_type         phase;
      logic [TIME_W-1:0] window_start;
      logic [HIT_W-1:0]  hit_count;
      outcome_t          awaited_outcomes [$];
      int                faults;
      int                fired;
      int                pulses;
      int                checked;

      function new();
         cfg = CFG_RESET;
         foreach (mag_ring[i]) mag_ring[i] = '0;
         mag_sum       = '0;
         ring_pos      = 0;
         ring_fill     = 0;
         prev_pressure = '0;
         prev_time     = '0;
         phase         = PH_ARMED;
         window_start  = '0;
         hit_count     = '0;
         faults        = 0;
         fired         = 0;
         pulses        = 0;
         checked       = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_SCENARIO:  cfg.scenario                = data[1:0];
            CSR_IMPACT:    cfg.impact_threshold        = data[15:0];
            CSR_FREE_FALL: cfg.free_fall_threshold     = data[15:0];
            CSR_VIBRATION: cfg.vibration_threshold     = data[15:0];
            CSR_PRES_RATE: cfg.pressure_rate_threshold = data[PRES_W-1:0];
            CSR_WINDOW:    cfg.window_ms               = data[15:0];
            CSR_CONFIRM:   cfg.confirm_samples         = data[HIT_W-1:0];
            default: ;
         endcase
      endfunction

      // floor of the square root, one result bit at a time
      function logic [15:0] magnitude_root(longint v);
         logic [15:0] root;
         logic [15:0] trial;
         root = '0;
         for (int b = 15; b >= 0; b--) begin
            trial = root | (16'd1 << b);
            if (longint'(trial) * longint'(trial) <= v) root = trial;
         end
         return root;
      endfunction

      function void note_sample(sample_t s);
         longint      ax, ay, az, sq, rise, lim;
         logic [15:0] mag;
         logic [31:0] dt;
         logic [31:0] elapsed;
         logic        ev;
         logic        act;
         outcome_t    o;
         ax  = longint'(s.accel_x);
         ay  = longint'(s.accel_y);
         az  = longint'(s.accel_z);
         sq  = ax * ax + ay * ay + az * az;
         ev  = 1'b0;
         act = 1'b0;
         if (cfg.scenario == KIND_MANUAL) begin
            // manual: no detector, phase held even in confirmed
            o = '{activate: 1'b0, event_now: 1'b0, phase: phase};
            awaited_outcomes.push_back(o);
            return;
         end
         case (cfg.scenario)
            KIND_FREE_FALL: begin
               mag = magnitude_root(sq);
               mag_sum = mag_sum - mag_ring[ring_pos] + mag;
               mag_ring[ring_pos] = mag;
               ring_pos = (ring_pos + 1 >= AVG_DEPTH) ? 0 : ring_pos + 1;
               if (ring_fill < AVG_DEPTH) ring_fill++;
               ev = (longint'(mag_sum) <
                     longint'(cfg.free_fall_threshold) * longint'(ring_fill)) &&
                    (s.vibration_hz > cfg.vibration_threshold);
            end
            KIND_SINKING: begin
               if (prev_time == '0) begin
                  // no reference yet: take this one, never fire
                  prev_pressure = s.pressure;
                  prev_time     = s.time_ms;
               end else begin
                  dt = s.time_ms - prev_time;
                  if (dt != '0) begin
                     rise = (longint'(s.pressure) - longint'(prev_pressure)) * 1000;
                     lim  = longint'(cfg.pressure_rate_threshold) * longint'(dt);
                     prev_pressure = s.pressure;
                     prev_time     = s.time_ms;
                     ev = rise > lim;
                  end
               end
            end
            default: begin
               ev = sq > longint'(cfg.impact_threshold) * longint'(cfg.impact_threshold);
            end
         endcase

         case (phase)
            PH_ARMED: begin
               if (ev) begin
                  phase        = PH_DETECTING;
                  window_start = s.time_ms;
                  hit_count    = '0;
               end
            end
            PH_DETECTING: begin
               elapsed = s.time_ms - window_start;
               if (ev) begin
                  if (hit_count != 8'hFF) hit_count++;
                  if (hit_count >= cfg.confirm_samples) phase = PH_CONFIRMED;
               end else if (elapsed > 32'(cfg.window_ms)) begin
                  phase = PH_ARMED;
               end
            end
            PH_CONFIRMED: begin
               phase = PH_ACTIVATED;
               act   = 1'b1;
            end
            default: ;
         endcase

         if (ev)  fired++;
         if (act) pulses++;
         o = '{activate: act, event_now: ev, phase: phase};
         awaited_outcomes.push_back(o);
      endfunction

      function void check_result(logic act, logic ev, logic [1:0] ph);
         outcome_t o;
         if (awaited_outcomes.size() == 0) begin
            faults++;
            $error("result word with nothing awaited: activate %0b event_now %0b phase %0d",
                   act, ev, ph);
            return;
         end
         o = awaited_outcomes.pop_front();
         checked++;
         if (act !== o.activate) begin
            faults++;
            $error("activate: expected %0b, actual %0b", o.activate, act);
         end
         if (ev !== o.event_now) begin
            faults++;
            $error("event_now: expected %0b, actual %0b", o.event_now, ev);
         end
         if (ph !== o.phase) begin
            faults++;
            $error("phase: expected %0d, actual %0d", o.phase, ph);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block signals; every input starts at a known value
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic signed [15:0]    req_accel_x_val = '0;
   logic signed [15:0]    req_accel_y_val = '0;
   logic signed [15:0]    req_accel_z_val = '0;
   logic [PRES_W-1:0]     req_pressure_val = '0;
   logic [VIB_W-1:0]      req_vibration_hz = '0;
   logic [TIME_W-1:0]     req_time_ms = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_activate;
   logic                  rsp_event_now;
   logic [1:0]            rsp_phase;

   always #5 clock = ~clock;

   sensor_event_confirm_detector dut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_accel_x_val  (req_accel_x_val),
      .req_accel_y_val  (req_accel_y_val),
      .req_accel_z_val  (req_accel_z_val),
      .req_pressure_val (req_pressure_val),
      .req_vibration_hz (req_vibration_hz),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_activate     (rsp_activate),
      .rsp_event_now    (rsp_event_now),
      .rsp_phase        (rsp_phase)
   );

   detector_scoreboard sb;

   sample_t           directed_q [$];
   reg_write_t        settings_q [$];
   logic [TIME_W-1:0] stamp_ms      = '0;   // running sample clock
   logic [PRES_W-1:0] pres_level    = '0;   // running pressure
   bit                gaps_on       = 1'b1; // sender may idle
   bit                stall_on      = 1'b1; // receiver may stall
   bit                allow_confirm = 1'b0; // hold off confirmation until the end
   int                stall_left    = 0;
   int                cycle_count   = 0;
   int                samples_sent  = 0;
   int                settings_done = 0;

   // -------------------------------------------------------------------------
   // Receiver: hold ready low for random bursts while stalls are on
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // check every result word at the edge that moves it
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result(rsp_activate, rsp_event_now, rsp_phase);
      end
   end

   // give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic sample_t pin(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                   logic [PRES_W-1:0] p, logic [VIB_W-1:0] v,
                                   logic [TIME_W-1:0] t);
      sample_t s;
      s = '{accel_x: ax, accel_y: ay, accel_z: az, pressure: p, vibration_hz: v,
            time_ms: t};
      return s;
   endfunction

   // quiet axes keep the moving average low; loud ones sweep the full range
   function automatic logic [15:0] axis_value(bit loud);
      if (!loud) begin
         if ($urandom_range(0, 7) == 0) return 16'd0;
         return 16'($urandom_range(0, 600)) - 16'd300;
      end
      case ($urandom_range(0, 5))
         0:       return AXIS_MIN;
         1:       return AXIS_MAX;
         default: return 16'($urandom());
      endcase
   endfunction

   // rare extreme, otherwise a typical value
   function automatic logic [31:0] edge_or(logic [31:0] top, logic [31:0] typical);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return top;
         default: return typical;
      endcase
   endfunction

   function automatic sample_t make_sample();
      sample_t     s;
      bit          loud;
      int          level;
      logic [31:0] step;
      if (directed_q.size() != 0) begin
         s = directed_q.pop_front();
      end else begin
         loud = ($urandom_range(0, 4) == 0);
         s.accel_x = axis_value(loud);
         s.accel_y = axis_value(loud);
         s.accel_z = axis_value(loud);
         case ($urandom_range(0, 9))
            0: s.pressure = '0;
            1: s.pressure = '1;
            2: s.pressure = PRES_W'($urandom());
            default: begin
               // drift the pressure, mostly upward
               level = int'(pres_level) + int'($urandom_range(0, 600)) - 200;
               if (level < 0) level = 0;
               if (level > 20'hFFFFF) level = 20'hFFFFF;
               s.pressure = PRES_W'(level);
            end
         endcase
         case ($urandom_range(0, 9))
            0: s.vibration_hz = '0;
            1: s.vibration_hz = '1;
            2: s.vibration_hz = VIB_W'($urandom());
            default: begin
               level = int'(sb.cfg.vibration_threshold) + int'($urandom_range(0, 6)) - 3;
               if (level < 0) level = 0;
               if (level > 16'hFFFF) level = 16'hFFFF;
               s.vibration_hz = VIB_W'(level);
            end
         endcase
         case ($urandom_range(0, 11))
            0: step = '0;
            1: step = $urandom();
            2: step = $urandom_range(1, 20);
            3: begin
               stamp_ms = '0;
               step     = '0;
            end
            default: step = $urandom_range(0, 2 * int'(sb.cfg.window_ms) + 10);
         endcase
         s.time_ms = stamp_ms + step;
      end
      // keep the phase short of confirmed: drop to a silent sample that lets
      // the window run out before the last confirmation can land
      if (!allow_confirm && sb.cfg.scenario != KIND_MANUAL && sb.phase == PH_DETECTING &&
          int'(sb.hit_count) + 1 >= int'(sb.cfg.confirm_samples)) begin
         s.accel_x      = '0;
         s.accel_y      = '0;
         s.accel_z      = '0;
         s.pressure     = '0;
         s.vibration_hz = '0;
         s.time_ms      = sb.window_start + 32'(sb.cfg.window_ms) + 1 +
                          $urandom_range(0, 40);
      end
      stamp_ms   = s.time_ms;
      pres_level = s.pressure;
      return s;
   endfunction

   function automatic void queue_reg(logic [CSR_IDX_W-1:0] index, int width,
                                     logic [31:0] value);
      reg_write_t w;
      w.index = index;
      w.data  = value;
      // fill unused upper bits now and then; the block must drop them
      if ($urandom_range(0, 1) == 1) w.data = w.data | ($urandom() << width);
      settings_q.push_back(w);
   endfunction

   // -------------------------------------------------------------------------
   // Drivers; each one starts and ends at a rising edge
   // -------------------------------------------------------------------------
   task automatic apply_settings();
      reg_write_t w;
      while (settings_q.size() != 0) begin
         w = settings_q.pop_front();
         csr_valid <= 1'b1;
         csr_index <= w.index;
         csr_wdata <= w.data;
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(w.index, w.data);
      end
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   task automatic run_samples(int count, bit stop_at_confirmed);
      sample_t s;
      for (int k = 0; k < count; k++) begin
         s = make_sample();
         req_valid        <= 1'b1;
         req_accel_x_val  <= s.accel_x;
         req_accel_y_val  <= s.accel_y;
         req_accel_z_val  <= s.accel_z;
         req_pressure_val <= s.pressure;
         req_vibration_hz <= s.vibration_hz;
         req_time_ms      <= s.time_ms;
         do @(posedge clock); while (!req_ready);
         sb.note_sample(s);
         samples_sent++;
         if (k == count - 1 || (stop_at_confirmed && sb.phase == PH_CONFIRMED)) begin
            req_valid <= 1'b0;
            break;
         end
         if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   // wait until every result word is back, then let the pipeline drain
   task automatic settle();
      while (sb.awaited_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      logic [1:0] scen;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // free fall under reset settings: axis extremes, pressure and
      // vibration extremes, then a calm stretch
      directed_q.push_back(pin(AXIS_MIN, AXIS_MIN, AXIS_MIN, '0, '1, 32'd0));
      directed_q.push_back(pin(AXIS_MAX, AXIS_MAX, AXIS_MAX, '1, '0, 32'd1));
      directed_q.push_back(pin('0, '0, '0, 20'd5, '1, 32'd2));
      directed_q.push_back(pin('0, '0, '0, 20'd5, '1, 32'd3));
      run_samples(directed_q.size(), 1'b0);

      // sinking: reference taken at time zero twice, same-time sample,
      // rise across the timestamp wrap, window expiry, then a flat reading
      settle();
      queue_reg(CSR_SCENARIO, 2, KIND_SINKING);
      queue_reg(CSR_UNUSED, 0, $urandom());
      apply_settings();
      directed_q.push_back(pin('0, '0, '0, 20'd100, '0, 32'd0));
      directed_q.push_back(pin('0, '0, '0, 20'd200, '0, 32'd0));
      directed_q.push_back(pin('0, '0, '0, 20'd300, '0, 32'hFFFF_FFF0));
      directed_q.push_back(pin('0, '0, '0, '1, '0, 32'hFFFF_FFF0));
      directed_q.push_back(pin('0, '0, '0, '1, '0, 32'd5));
      directed_q.push_back(pin('0, '0, '0, '0, '0, 32'd506));
      directed_q.push_back(pin('0, '0, '0, '1, '0, 32'd600));
      directed_q.push_back(pin('0, '0, '0, '1, '0, 32'd700));
      run_samples(directed_q.size(), 1'b0);

      // impact at the top threshold: the largest magnitude stays below it
      settle();
      queue_reg(CSR_SCENARIO, 2, KIND_IMPACT);
      queue_reg(CSR_IMPACT, 16, 32'hFFFF);
      apply_settings();
      directed_q.push_back(pin(AXIS_MIN, AXIS_MIN, AXIS_MIN, '0, '0, 32'd800));
      run_samples(directed_q.size(), 1'b0);

      // impact at zero threshold: silence misses, any motion hits
      settle();
      queue_reg(CSR_IMPACT, 16, 32'd0);
      apply_settings();
      directed_q.push_back(pin('0, '0, '0, '0, '0, 32'd850));
      directed_q.push_back(pin(16'd1, '0, '0, '0, '0, 32'd900));
      directed_q.push_back(pin(16'hFFFF, 16'hFFFF, 16'hFFFF, '0, '0, 32'd950));
      run_samples(directed_q.size(), 1'b0);

      // manual: the phase holds while detecting
      settle();
      queue_reg(CSR_SCENARIO, 2, KIND_MANUAL);
      apply_settings();
      directed_q.push_back(pin(AXIS_MAX, AXIS_MIN, AXIS_MAX, '1, '1, '1));
      directed_q.push_back(pin(AXIS_MIN, AXIS_MAX, AXIS_MIN, '0, '0, 32'd2000));
      run_samples(directed_q.size(), 1'b0);

      // random segments, each under fresh settings; every third one runs
      // without idling on either side
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         settle();
         scen = (seg < 8) ? 2'(seg % 4) : 2'($urandom_range(0, 3));
         queue_reg(CSR_SCENARIO, 2, scen);
         if (seg == 0 || $urandom_range(0, 1) == 1)
            queue_reg(CSR_IMPACT, 16, edge_or(32'hFFFF, $urandom_range(0, 20000)));
         if (seg == 0 || $urandom_range(0, 1) == 1)
            queue_reg(CSR_FREE_FALL, 16, edge_or(32'hFFFF, $urandom_range(0, 3000)));
         if (seg == 0 || $urandom_range(0, 1) == 1)
            queue_reg(CSR_VIBRATION, 16, edge_or(32'hFFFF, $urandom_range(0, 65535)));
         if (seg == 0 || $urandom_range(0, 1) == 1)
            queue_reg(CSR_PRES_RATE, 20, edge_or(32'hFFFFF, $urandom_range(0, 3000)));
         if (seg == 0 || $urandom_range(0, 1) == 1)
            queue_reg(CSR_WINDOW, 16, edge_or(32'hFFFF, $urandom_range(0, 1500)));
         if (seg == 0 || $urandom_range(0, 1) == 1)
            queue_reg(CSR_CONFIRM, 8, edge_or(32'hFF, $urandom_range(1, 12)));
         apply_settings();
         gaps_on  = (seg % 3 != 2);
         stall_on = (seg % 3 != 2);
         run_samples(SEG_SAMPLES, 1'b0);
      end

      // closing stretch, no idling: confirm on the first hit in detecting,
      // hold confirmed under manual, then activate once and stay there
      gaps_on       = 1'b0;
      stall_on      = 1'b0;
      allow_confirm = 1'b1;
      settle();
      queue_reg(CSR_SCENARIO, 2, KIND_IMPACT);
      queue_reg(CSR_IMPACT, 16, 32'd0);
      queue_reg(CSR_CONFIRM, 8, 32'd0);
      apply_settings();
      run_samples(200, 1'b1);

      settle();
      queue_reg(CSR_SCENARIO, 2, KIND_MANUAL);
      apply_settings();
      run_samples(12, 1'b0);

      settle();
      queue_reg(CSR_SCENARIO, 2, $urandom_range(0, 2));
      queue_reg(CSR_CONFIRM, 8, 32'hFF);
      apply_settings();
      run_samples(60, 1'b0);

      settle();
      $display("Run drove %0d sample words under %0d register settings; %0d detector hits.",
               samples_sent, settings_done, sb.fired);
      $display("Checked %0d result words, %0d activate pulses, %0d field errors.",
               sb.checked, sb.pulses, sb.faults);
      if (sb.faults == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
